// ===== sv/mtas_pkg.sv =====
`timescale 1ns / 1ps

package mtas_pkg;

	// Field widths
	localparam int USAGE_W = 8;
	localparam int PREF_W  = 5;
	localparam int MASK_W  = 32;
	localparam int SIZE_W  = 48;
	localparam int BYTES_W = 64;
	localparam int COUNT_W = 13;

	// Parameter defaults
	localparam int TYPE_COUNT_DEF = 32;
	localparam int MAX_ITEMS_DEF  = 4096;
	localparam int COUNT_FIELD_MAX = 8191;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_USAGE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_MASK  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_PREF  = 2'd2;

	// One per-type accumulator entry
	typedef struct packed {
		logic [BYTES_W-1:0] bytes;
		logic [COUNT_W-1:0] count;
		logic [MASK_W-1:0]  cmn;
	} entry_t;

	// Sequencer to store
	typedef struct packed {
		logic acc;
		logic clear;
	} store_cmd_t;

	localparam entry_t ENTRY_RESET = '{bytes: '0, count: '0, cmn: '1};

endpackage

// ===== sv/memory_type_anchor_selector.sv =====
`timescale 1ns / 1ps

// Memory type anchor selector.
// Input channel (in_valid / in_stall) carries one reservation per request.
// Reservations whose usage matches origin_usage are folded into TYPE_COUNT
// per-type accumulators (saturating byte sum, item count, AND of type masks) by one
// shared add/compare unit that walks the types, one type per cycle.
// Steps per request:
//   non-matching, not last : accepted straight back in idle
//   matching               : accumulate walk over every type
//   is_last                : after that, reads the origin's preferred
//                            entry, scans the viable types and loads the
//                            result.
// in_stall is high whenever the sequencer is not idle.
// The output channel (out_valid / out_stall) has its own result register,
// so the next set may start while a result waits; only the load of a new
// result waits for the register to free up. Result then holds stable.
// Reset clears config to zero and drops all per-type valid bits at once,
// so the store reads as cleared in the first cycle after reset; no sweep.
// Config writes (cfg_we) take effect at once and must come while idle.

module memory_type_anchor_selector #(
	parameter int TYPE_COUNT = mtas_pkg::TYPE_COUNT_DEF,
	parameter int MAX_ITEMS  = mtas_pkg::MAX_ITEMS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// config
	input  logic                                cfg_we,
	input  logic [mtas_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mtas_pkg::MASK_W-1:0]         cfg_data,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [mtas_pkg::USAGE_W-1:0]        item_usage,
	input  logic [mtas_pkg::PREF_W-1:0]         item_preferred_index,
	input  logic [mtas_pkg::MASK_W-1:0]         item_type_mask,
	input  logic [mtas_pkg::SIZE_W-1:0]         item_size,
	input  logic                                is_last,
	// output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [mtas_pkg::PREF_W-1:0]         best_type_index,
	output logic [mtas_pkg::COUNT_W-1:0]        group_size,
	output logic [mtas_pkg::MASK_W-1:0]         common_type_mask,
	output logic                                status
);

	localparam int IW = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;
	localparam int CountCap = (MAX_ITEMS < mtas_pkg::COUNT_FIELD_MAX)
		? MAX_ITEMS : mtas_pkg::COUNT_FIELD_MAX;
	localparam logic [IW-1:0] IdxLast = IW'(TYPE_COUNT - 1);
	localparam logic [mtas_pkg::PREF_W:0] TypeCountW = (mtas_pkg::PREF_W + 1)'(TYPE_COUNT);

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ACC  = 3'd1;
	localparam logic [2:0] S_PREF = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0] state_q;
	logic [IW-1:0] idx_q;

	// config registers
	logic [mtas_pkg::USAGE_W-1:0] origin_usage_q;
	logic [mtas_pkg::MASK_W-1:0]  origin_mask_q;
	logic [mtas_pkg::PREF_W-1:0]  origin_pref_q;

	// latched request
	logic [TYPE_COUNT-1:0]         both_q;
	logic [mtas_pkg::SIZE_W-1:0]   size_q;
	logic [mtas_pkg::MASK_W-1:0]   mask_q;
	logic                          last_q;

	logic [TYPE_COUNT-1:0] viable_q;

	// running best during the selection scan
	logic [mtas_pkg::PREF_W-1:0]  best_idx_q;
	logic [mtas_pkg::BYTES_W-1:0] best_bytes_q;
	logic [mtas_pkg::COUNT_W-1:0] best_cnt_q;
	logic [mtas_pkg::MASK_W-1:0]  best_and_q;

	// result register
	logic                          out_valid_q;
	logic [mtas_pkg::PREF_W-1:0]   out_idx_q;
	logic [mtas_pkg::COUNT_W-1:0]  out_cnt_q;
	logic [mtas_pkg::MASK_W-1:0]   out_mask_q;
	logic                          out_status_q;

	logic in_accept;
	logic usage_hit;
	logic pref_in_range;
	logic item_pref_in_range;
	logic emit_go;
	logic scan_take;
	logic [IW-1:0] rd_idx;
	mtas_pkg::store_cmd_t cmd;
	mtas_pkg::entry_t rd_data;

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign usage_hit = (item_usage == origin_usage_q);
	assign pref_in_range      = ({1'b0, origin_pref_q} < TypeCountW);
	assign item_pref_in_range = ({1'b0, item_preferred_index} < TypeCountW);
	assign emit_go   = (state_q == S_EMIT) && (!out_valid_q || !out_stall);

	// a viable type other than the origin's preferred one that beats the best
	assign scan_take = viable_q[idx_q]
		&& (mtas_pkg::PREF_W'(idx_q) != origin_pref_q)
		&& ((rd_data.bytes > best_bytes_q)
			|| ((rd_data.bytes == best_bytes_q) && (rd_data.count > best_cnt_q)));

	assign rd_idx    = (state_q == S_PREF) ? origin_pref_q[IW-1:0] : idx_q;
	assign cmd.acc   = (state_q == S_ACC) && both_q[idx_q];
	assign cmd.clear = emit_go;

	mtas_store #(
		.TYPE_COUNT (TYPE_COUNT),
		.COUNT_CAP  (CountCap)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rd_idx  (rd_idx),
		.size    (size_q),
		.mask    (mask_q),
		.rd_data (rd_data)
	);

	// config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_usage_q <= '0;
			origin_mask_q  <= '0;
			origin_pref_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mtas_pkg::CFG_ORIGIN_USAGE: origin_usage_q <= cfg_data[mtas_pkg::USAGE_W-1:0];
				mtas_pkg::CFG_ORIGIN_MASK:  origin_mask_q  <= cfg_data;
				mtas_pkg::CFG_ORIGIN_PREF:  origin_pref_q  <= cfg_data[mtas_pkg::PREF_W-1:0];
				default: ;
			endcase
		end
	end

	// request payload latch
	always_ff @(posedge clk) begin
		if (in_accept) begin
			both_q <= usage_hit
				? (item_type_mask[TYPE_COUNT-1:0] & origin_mask_q[TYPE_COUNT-1:0]) : '0;
			size_q <= item_size;
			mask_q <= item_type_mask;
			last_q <= is_last;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (in_accept) begin
						if (usage_hit) begin
							state_q <= S_ACC;
						end else if (is_last) begin
							state_q <= S_PREF;
						end
					end
				end
				S_ACC: begin
					if (idx_q == IdxLast) begin
						idx_q   <= '0;
						state_q <= last_q ? S_PREF : S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_PREF: begin
					idx_q   <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (idx_q == IdxLast) begin
						idx_q   <= '0;
						state_q <= S_EMIT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// viability: item's preferred type supported by the origin
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			viable_q <= '0;
		end else if (emit_go) begin
			viable_q <= '0;
		end else if (in_accept && usage_hit && item_pref_in_range
				&& origin_mask_q[item_preferred_index]) begin
			viable_q[item_preferred_index[IW-1:0]] <= 1'b1;
		end
	end

	// running best; origin's preferred type seeds it and wins exact ties
	always_ff @(posedge clk) begin
		if (state_q == S_PREF) begin
			best_idx_q <= origin_pref_q;
			if (pref_in_range) begin
				best_bytes_q <= rd_data.bytes;
				best_cnt_q   <= rd_data.count;
				best_and_q   <= rd_data.cmn;
			end else begin
				best_bytes_q <= mtas_pkg::ENTRY_RESET.bytes;
				best_cnt_q   <= mtas_pkg::ENTRY_RESET.count;
				best_and_q   <= mtas_pkg::ENTRY_RESET.cmn;
			end
		end else if (state_q == S_SCAN && scan_take) begin
			best_idx_q   <= mtas_pkg::PREF_W'(idx_q);
			best_bytes_q <= rd_data.bytes;
			best_cnt_q   <= rd_data.count;
			best_and_q   <= rd_data.cmn;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_idx_q    <= best_idx_q;
			out_cnt_q    <= best_cnt_q;
			out_mask_q   <= origin_mask_q & best_and_q;
			out_status_q <= !(pref_in_range && viable_q[origin_pref_q[IW-1:0]]);
		end
	end

	assign out_valid        = out_valid_q;
	assign best_type_index  = out_idx_q;
	assign group_size       = out_cnt_q;
	assign common_type_mask = out_mask_q;
	assign status           = out_status_q;

	// a closing request always starts a walk (accumulate or selection)
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && is_last |=> in_stall)
		else $error("closing request did not start selection");

	// loading a result clears viability and returns to idle
	a_emit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |=> (viable_q == '0) && (state_q == S_IDLE) && out_valid)
		else $error("emit did not clear store or load result");

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> !emit_go)
		else $error("result overwritten while stalled");

	// accumulation only while the walk is running
	a_acc_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc |-> (state_q == S_ACC) && !cmd.clear)
		else $error("store written outside accumulate walk");

endmodule

// ===== sv/mtas_store.sv =====
`timescale 1ns / 1ps

module mtas_store #(
	parameter int TYPE_COUNT = mtas_pkg::TYPE_COUNT_DEF,
	parameter int COUNT_CAP  = mtas_pkg::MAX_ITEMS_DEF,
	localparam int IW = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mtas_pkg::store_cmd_t              cmd,
	input  logic [IW-1:0]                     rd_idx,
	input  logic [mtas_pkg::SIZE_W-1:0]       size,
	input  logic [mtas_pkg::MASK_W-1:0]       mask,
	output mtas_pkg::entry_t                  rd_data
);

	localparam logic [mtas_pkg::COUNT_W-1:0] Cap = mtas_pkg::COUNT_W'(COUNT_CAP);

	mtas_pkg::entry_t mem_q [TYPE_COUNT];
	logic [TYPE_COUNT-1:0] valid_q;

	mtas_pkg::entry_t cur;
	mtas_pkg::entry_t nxt;
	logic [mtas_pkg::BYTES_W:0] sum;

	// invalid entries read as their reset value
	always_comb begin
		cur = valid_q[rd_idx] ? mem_q[rd_idx] : mtas_pkg::ENTRY_RESET;
		rd_data = cur;
		sum = {1'b0, cur.bytes}
			+ {{(mtas_pkg::BYTES_W + 1 - mtas_pkg::SIZE_W){1'b0}}, size};
		nxt.bytes = sum[mtas_pkg::BYTES_W] ? '1 : sum[mtas_pkg::BYTES_W-1:0];
		nxt.count = (cur.count < Cap) ? cur.count + 1'b1 : cur.count;
		nxt.cmn   = cur.cmn & mask;
	end

	always_ff @(posedge clk) begin
		if (cmd.acc) begin
			mem_q[rd_idx] <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.clear) begin
			valid_q <= '0;
		end else if (cmd.acc) begin
			valid_q[rd_idx] <= 1'b1;
		end
	end

endmodule
